// ===== hdl/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg: shared types and codes for the keyed record table
// Opcode and status codes, the record layout held by each cell, and the
// control and result groups passed between the table modules.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int SEG_MAX         = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EXISTS    = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [30:0]        key;
    logic signed [31:0] qty;
    logic [30:0]        price;
  } record_t;

  typedef struct packed {
    logic shift_en;
    logic wr_en;
    logic cmp_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic    hit;
    record_t rec;
  } scan_res_t;

endpackage

// ===== hdl/krt_if.sv =====
// ----------------------------------------------------------------------------
// krt_if: request and response channels of the keyed record table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface krt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [30:0]        part_key;
  logic signed [31:0] initial_quantity;
  logic [30:0]        item_price;
  logic signed [31:0] quantity_change;

  modport source (output valid, output opcode, output part_key, output initial_quantity,
                  output item_price, output quantity_change, input ready);
  modport sink   (input valid, input opcode, input part_key, input initial_quantity,
                  input item_price, input quantity_change, output ready);
endinterface

interface krt_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] on_hand;
  logic [30:0]        unit_price;

  modport source (output valid, output status, output on_hand, output unit_price,
                  input ready);
  modport sink   (input valid, input status, input on_hand, input unit_price,
                  output ready);
endinterface

// ===== hdl/kr_cell.sv =====
// ----------------------------------------------------------------------------
// kr_cell: one record slot of the table chain
// Holds one record, shifts it to the next cell on insert, compares its key
// against the broadcast key and rewrites its quantity on a matched update.
// ----------------------------------------------------------------------------
module kr_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  krt_pkg::cell_ctrl_t ctrl,
  input  krt_pkg::record_t    shift_in,
  input  logic signed [31:0]  wr_qty,
  input  logic [30:0]         query_key,
  input  logic [CNT_W-1:0]    count,
  output krt_pkg::record_t    rec,
  output logic                match
);

  logic occupied;

  assign occupied = CNT_W'(INDEX) < count;

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      rec <= shift_in;
    end else if (ctrl.wr_en && match) begin
      rec.qty <= wr_qty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.cmp_en) begin
      match <= occupied && (rec.key == query_key);
    end
  end

endmodule

// ===== hdl/kr_scan.sv =====
// ----------------------------------------------------------------------------
// kr_scan: match collector
// Walks the cell match bits one segment per cycle and gathers the record of
// the matching cell.
// ----------------------------------------------------------------------------
module kr_scan #(
  parameter int DEPTH = krt_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DEPTH-1:0]   match,
  input  krt_pkg::record_t   recs [DEPTH],
  output logic               done,
  output krt_pkg::scan_res_t res
);

  localparam int SEG   = (DEPTH < krt_pkg::SEG_MAX) ? DEPTH : krt_pkg::SEG_MAX;
  localparam int NSEG  = (DEPTH + SEG - 1) / SEG;
  localparam int SEG_W = (NSEG > 1) ? $clog2(NSEG) : 1;

  logic [SEG-1:0]   grp_match [NSEG];
  krt_pkg::record_t grp_rec   [NSEG][SEG];
  logic [SEG_W-1:0] seg;
  logic             busy;
  logic             sel_hit;
  krt_pkg::record_t sel_rec;

  for (genvar g = 0; g < NSEG; g++) begin : g_seg
    for (genvar j = 0; j < SEG; j++) begin : g_lane
      if (g * SEG + j < DEPTH) begin : g_used
        assign grp_match[g][j] = match[g * SEG + j];
        assign grp_rec[g][j]   = recs[g * SEG + j];
      end else begin : g_pad
        assign grp_match[g][j] = 1'b0;
        assign grp_rec[g][j]   = '0;
      end
    end
  end

  always_comb begin
    sel_hit = |grp_match[seg];
    sel_rec = '0;
    for (int j = 0; j < SEG; j++) begin
      if (grp_match[seg][j]) begin
        sel_rec = sel_rec | grp_rec[seg][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      seg  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        seg  <= '0;
      end else if (busy) begin
        if (seg == SEG_W'(NSEG - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          seg <= seg + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      res <= '0;
    end else if (busy) begin
      res.hit <= res.hit | sel_hit;
      res.rec <= res.rec | sel_rec;
    end
  end

endmodule

// ===== hdl/keyed_record_table_core.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table_core: associative key/value record table
// A chain of record cells with parallel key compare, a segmented match scan
// and a commit step that appends, reads back or updates with saturation.
// ----------------------------------------------------------------------------
// Flow: a request beat passes the match, scan and commit states in turn; the
//   match scan walks 16 cells per cycle.
//   One request at a time; an unused opcode is taken and gets no response.
//   A waiting response does not stop the next request from being taken.
// Reset: clears the entry count and control state; cell contents are kept.
// ----------------------------------------------------------------------------
module keyed_record_table_core #(
  parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  krt_req_if.sink   req,
  krt_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MATCH  = 4'b0010,
    S_SCAN   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [1:0]         opcode;
  logic [30:0]        part_key;
  logic signed [31:0] initial_quantity;
  logic [30:0]        item_price;
  logic signed [31:0] quantity_change;
  logic [CNT_W-1:0]   count;

  logic               out_valid;
  logic [1:0]         out_status;
  logic signed [31:0] out_on_hand;
  logic [30:0]        out_unit_price;

  krt_pkg::cell_ctrl_t ctrl;
  krt_pkg::record_t    new_rec;
  krt_pkg::record_t    recs [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match;
  logic                scan_done;
  krt_pkg::scan_res_t  found;

  logic               accept;
  logic               commit_go;
  logic               full;
  logic signed [32:0] sum;
  logic signed [31:0] sat_qty;
  logic [1:0]         res_status;
  logic signed [31:0] res_qty;
  logic [30:0]        res_price;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign commit_go = (state == S_COMMIT) && (!out_valid || rsp.ready);
  assign full      = (count == CNT_W'(TABLE_DEPTH));

  assign new_rec.key   = part_key;
  assign new_rec.qty   = initial_quantity;
  assign new_rec.price = item_price;

  assign sum     = {found.rec.qty[31], found.rec.qty} + {quantity_change[31], quantity_change};
  assign sat_qty = (sum[32] != sum[31]) ? (sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                                        : sum[31:0];

  always_comb begin
    ctrl.cmp_en   = (state == S_MATCH);
    ctrl.shift_en = 1'b0;
    ctrl.wr_en    = 1'b0;
    res_status    = krt_pkg::ST_OK;
    res_qty       = '0;
    res_price     = '0;
    case (opcode)
      krt_pkg::OP_INSERT: begin
        if (full) begin
          res_status = krt_pkg::ST_FULL;
        end else if (found.hit) begin
          res_status = krt_pkg::ST_EXISTS;
        end else begin
          ctrl.shift_en = commit_go;
        end
      end
      krt_pkg::OP_SEARCH: begin
        if (found.hit) begin
          res_qty   = found.rec.qty;
          res_price = found.rec.price;
        end else begin
          res_status = krt_pkg::ST_NOT_FOUND;
        end
      end
      krt_pkg::OP_UPDATE: begin
        if (found.hit) begin
          ctrl.wr_en = commit_go;
          res_qty    = sat_qty;
          res_price  = found.rec.price;
        end else begin
          res_status = krt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        res_status = krt_pkg::ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    krt_pkg::record_t shift_in;
    if (i == 0) begin : g_head
      assign shift_in = new_rec;
    end else begin : g_body
      assign shift_in = recs[i-1];
    end
    kr_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .shift_in  (shift_in),
      .wr_qty    (sat_qty),
      .query_key (part_key),
      .count     (count),
      .rec       (recs[i]),
      .match     (match[i])
    );
  end

  kr_scan #(
    .DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_MATCH),
    .match (match),
    .recs  (recs),
    .done  (scan_done),
    .res   (found)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && req.opcode != krt_pkg::OP_NONE) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH:  state_next = S_SCAN;
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit_go) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.shift_en) begin
        count <= count + 1'b1;
      end
      if (commit_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      opcode           <= req.opcode;
      part_key         <= req.part_key;
      initial_quantity <= req.initial_quantity;
      item_price       <= req.item_price;
      quantity_change  <= req.quantity_change;
    end
    if (commit_go) begin
      out_status     <= res_status;
      out_on_hand    <= res_qty;
      out_unit_price <= res_price;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.on_hand    = out_on_hand;
  assign rsp.unit_price = out_unit_price;

endmodule

// ===== hdl/kr_checker.sv =====
// ----------------------------------------------------------------------------
// kr_checker: port-level checks for the keyed record table
// Watches the request and response channels of the top level over time.
// ----------------------------------------------------------------------------
module kr_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  req_opcode,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic [31:0] rsp_on_hand,
  input logic [30:0] rsp_unit_price
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response beat dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_on_hand)
                                && $stable(rsp_unit_price))
    else $error("stalled response payload changed");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_opcode != krt_pkg::OP_NONE |=> !req_ready)
    else $error("request taken while previous one in flight");

  a_refusal_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != krt_pkg::ST_OK |-> rsp_on_hand == '0 && rsp_unit_price == '0)
    else $error("refused response carries data");

endmodule

bind keyed_record_table_core kr_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_opcode     (req.opcode),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_on_hand    (rsp.on_hand),
  .rsp_unit_price (rsp.unit_price)
);

// ===== tb/krt_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_table_checker: scoreboard for the keyed record table
// Watches the request and response channels, keeps its own copy of the
// record table, predicts the reply to every accepted request but OP_NONE
// and compares each response beat field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module krt_table_checker #(
  parameter int DEPTH = krt_pkg::TABLE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  krt_req_if   req,
  krt_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding,
  output int   checked,
  output int   full_refusals,
  output int   saturations
);
  import krt_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] on_hand;
    logic [30:0]        unit_price;
  } reply_t;

  record_t     records [DEPTH];
  int unsigned fill;
  reply_t      pending_replies[$];
  reply_t      want;

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic reply_t predict_reply(input logic [1:0] op, input logic [30:0] k,
                                           input logic signed [31:0] q,
                                           input logic [30:0] p,
                                           input logic signed [31:0] c);
    reply_t             r;
    int                 slot;
    logic               found;
    logic signed [32:0] sum;
    r     = '0;
    slot  = 0;
    found = 1'b0;
    for (int i = 0; i < fill; i++) begin
      if (!found && records[i].key == k) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (op == OP_INSERT) begin
      if (fill >= DEPTH) begin
        r.status = ST_FULL;
        full_refusals++;
      end else if (found) begin
        r.status = ST_EXISTS;
      end else begin
        records[fill].key   = k;
        records[fill].qty   = q;
        records[fill].price = p;
        fill++;
        r.status = ST_OK;
      end
    end else if (!found) begin
      r.status = ST_NOT_FOUND;
    end else begin
      if (op == OP_UPDATE) begin
        sum = {records[slot].qty[31], records[slot].qty} + {c[31], c};
        if (sum[32] != sum[31]) begin
          records[slot].qty = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          saturations++;
        end else begin
          records[slot].qty = sum[31:0];
        end
      end
      r.status     = ST_OK;
      r.on_hand    = records[slot].qty;
      r.unit_price = records[slot].price;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      pending_replies.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_replies.size() == 0) begin
          flag_mismatch("response beat with no request pending");
        end else begin
          want = pending_replies.pop_front();
          checked++;
          if (rsp.status !== want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
          if (rsp.on_hand !== want.on_hand)
            flag_mismatch($sformatf("on_hand %0d, expected %0d", rsp.on_hand, want.on_hand));
          if (rsp.unit_price !== want.unit_price)
            flag_mismatch($sformatf("unit_price %0d, expected %0d",
                                    rsp.unit_price, want.unit_price));
        end
      end
      if (req.valid && req.ready && req.opcode != OP_NONE) begin
        pending_replies.push_back(predict_reply(req.opcode, req.part_key,
                                                req.initial_quantity, req.item_price,
                                                req.quantity_change));
      end
    end
    outstanding <= pending_replies.size();
  end

endmodule

// ===== tb/tb_keyed_record_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_record_table_core: testbench for the keyed record table
// Drives a directed set of inserts, searches and updates on the key and
// quantity extremes, then random traffic that mixes hits, misses, duplicate
// inserts, saturating updates and a table that runs full, with random idle
// cycles on both channels. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_keyed_record_table_core;
  import krt_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int ITEMS = 1750;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic no_idle = 1'b0;
  int   cycles;
  int   n_sent;
  int   n_op [4];
  int   chk_mismatches;
  int   chk_outstanding;
  int   chk_checked;
  int   chk_full;
  int   chk_sat;

  logic [30:0] key_pool[$];

  krt_req_if req_ch ();
  krt_rsp_if rsp_ch ();

  keyed_record_table_core #(.TABLE_DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  krt_table_checker #(.DEPTH(DEPTH)) chk (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .mismatches    (chk_mismatches),
    .outstanding   (chk_outstanding),
    .checked       (chk_checked),
    .full_refusals (chk_full),
    .saturations   (chk_sat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [30:0] k,
                              input logic signed [31:0] q, input logic [30:0] p,
                              input logic signed [31:0] c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid            <= 1'b1;
    req_ch.opcode           <= op;
    req_ch.part_key         <= k;
    req_ch.initial_quantity <= q;
    req_ch.item_price       <= p;
    req_ch.quantity_change  <= c;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    n_sent++;
    n_op[op]++;
  endtask

  function automatic logic [30:0] pick_key(input int pool_pct);
    if (key_pool.size() > 0 && $urandom_range(0, 99) < pool_pct)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return 31'($urandom);
  endfunction

  function automatic logic signed [31:0] pick_quantity();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_change();
    case ($urandom_range(0, 9))
      0, 1:    return 32'sh7FFF_FFFF;
      2, 3:    return 32'sh8000_0000;
      4, 5, 6: return 32'($urandom_range(0, 2000)) - 32'sd1000;
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [30:0] pick_price();
    case ($urandom_range(0, 9))
      0:       return 31'h7FFF_FFFF;
      1:       return 31'h0;
      default: return 31'($urandom);
    endcase
  endfunction

  // response side: ready follows its own random idle pattern
  initial begin
    int gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  initial begin
    int          sel;
    logic [30:0] k;
    req_ch.valid            <= 1'b0;
    req_ch.opcode           <= OP_INSERT;
    req_ch.part_key         <= '0;
    req_ch.initial_quantity <= '0;
    req_ch.item_price       <= '0;
    req_ch.quantity_change  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_SEARCH, 31'h0, 32'sd0, 31'h0, 32'sd0);
    send_request(OP_UPDATE, 31'h7FFF_FFFF, 32'sd0, 31'h0, 32'sd5);
    send_request(OP_INSERT, 31'h0, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sd0);
    send_request(OP_INSERT, 31'h7FFF_FFFF, 32'sh8000_0000, 31'h0, 32'sd0);
    send_request(OP_INSERT, 31'h0, 32'sd7, 31'd9, 32'sd0);
    send_request(OP_SEARCH, 31'h0, 32'sd0, 31'h0, 32'sd0);
    send_request(OP_SEARCH, 31'h7FFF_FFFF, 32'sd0, 31'h0, 32'sd0);
    send_request(OP_UPDATE, 31'h0, 32'sd0, 31'h0, 32'sd1);
    send_request(OP_UPDATE, 31'h7FFF_FFFF, 32'sd0, 31'h0, -32'sd1);
    send_request(OP_UPDATE, 31'h0, 32'sd0, 31'h0, 32'sh8000_0000);
    send_request(OP_UPDATE, 31'h7FFF_FFFF, 32'sd0, 31'h0, 32'sh7FFF_FFFF);
    send_request(OP_NONE, 31'h7FFF_FFFF, -32'sd1, 31'h7FFF_FFFF, -32'sd1);
    send_request(OP_INSERT, 31'd5, 32'sd0, 31'd12345, 32'sd0);
    send_request(OP_UPDATE, 31'd5, 32'sd0, 31'h0, 32'sh8000_0000);
    send_request(OP_UPDATE, 31'd5, 32'sd0, 31'h0, 32'sh8000_0000);
    send_request(OP_UPDATE, 31'd5, 32'sd0, 31'h0, 32'sh7FFF_FFFF);
    send_request(OP_SEARCH, 31'd5, 32'sd0, 31'h0, 32'sd0);
    send_request(OP_SEARCH, 31'h2AAA_AAAA, 32'sd0, 31'h0, 32'sd0);
    send_request(OP_UPDATE, 31'h5555_5555, 32'sd0, 31'h0, 32'sd3);
    send_request(OP_NONE, 31'h0, 32'sd0, 31'h0, 32'sd0);
    key_pool.push_back(31'h0);
    key_pool.push_back(31'h7FFF_FFFF);
    key_pool.push_back(31'd5);

    for (int i = 0; i < ITEMS; i++) begin
      if (i % 300 == 0) no_idle = 1'b0;
      if (i % 300 == 150) no_idle = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        k = pick_key(35);
        key_pool.push_back(k);
        send_request(OP_INSERT, k, pick_quantity(), pick_price(), 32'($urandom));
      end else if (sel < 60) begin
        send_request(OP_SEARCH, pick_key(65), 32'($urandom), 31'($urandom), 32'($urandom));
      end else if (sel < 95) begin
        send_request(OP_UPDATE, pick_key(65), 32'($urandom), 31'($urandom), pick_change());
      end else begin
        send_request(OP_NONE, 31'($urandom), 32'($urandom), 31'($urandom), 32'($urandom));
      end
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (chk_outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d requests: %0d insert, %0d search, %0d update, %0d unused opcode.",
             n_sent, n_op[OP_INSERT], n_op[OP_SEARCH], n_op[OP_UPDATE], n_op[OP_NONE]);
    $display("Checked %0d responses; %0d inserts refused on a full table, %0d saturated.",
             chk_checked, chk_full, chk_sat);
    if (chk_outstanding != 0)
      $display("%0d expected responses never arrived", chk_outstanding);
    if (chk_mismatches == 0 && chk_outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
